/* rtl/core/wrapping_timer_delay_tracker_unit_defines.svh */
// Assertion macros for the RTL file that checks its own logic.
`ifndef WRAPPING_TIMER_DELAY_TRACKER_UNIT_DEFINES_SVH
`define WRAPPING_TIMER_DELAY_TRACKER_UNIT_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define WTDT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define WTDT_NEVER(lbl, expr, msg) \
    `WTDT_ASSERT(lbl, !(expr), msg)

`endif

/* rtl/core/wtdt_pkg.sv */
package wtdt_pkg;

    localparam int TIMER_W   = 32;
    localparam int TIMER_W24 = 24;
    localparam int WRAP_W    = 12;
    // ticks < 3.58 * 2^32 fits in 34 bits
    localparam int TICK_W    = 34;
    // floor(2d/25) for a 32-bit d stays below 2^29
    localparam int QUO_W     = 29;

    // floor(2d/25) = (d * RECIP_2_25) >> RECIP_SHIFT, exact for 32-bit d
    localparam int               RECIP_W     = 33;
    localparam logic [RECIP_W-1:0] RECIP_2_25 = 33'h1_47AE_147B;
    localparam int               RECIP_SHIFT = 36;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [TIMER_W-1:0] delay;
        logic [TIMER_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic               opcode;
        logic [TIMER_W-1:0] sample;
        logic [TICK_W-1:0]  ticks;
    } tick_item_t;

endpackage

/* rtl/core/wtdt_tick_pipe.sv */
module wtdt_tick_pipe
    import wtdt_pkg::*;
#(
    parameter int DELAY_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  item_t      in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output tick_item_t out_item
);

    localparam int DW = (DELAY_BITS < TIMER_W) ? DELAY_BITS : TIMER_W;

    localparam int PROD_W = TIMER_W + RECIP_W;

    // stage 1: registered input word
    logic               v1_reg;
    logic               op1_reg;
    logic [DW-1:0]      d1_reg;
    logic [TIMER_W-1:0] smp1_reg;

    // stage 2: reciprocal product taken apart
    logic               v2_reg;
    logic               op2_reg;
    logic [DW-1:0]      d2_reg;
    logic [TIMER_W-1:0] smp2_reg;
    logic [QUO_W-1:0]   q2_reg;

    // stage 3: tick count
    logic               v3_reg;
    logic               op3_reg;
    logic [TIMER_W-1:0] smp3_reg;
    logic [TICK_W-1:0]  ticks3_reg;

    logic               rdy1;
    logic               rdy2;
    logic               rdy3;
    logic [TIMER_W-1:0] d_ext;
    logic [PROD_W-1:0]  prod;
    logic [QUO_W-1:0]   quo;
    logic [TICK_W-1:0]  d_wide;
    logic [TICK_W-1:0]  ticks;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign d_ext = TIMER_W'(d1_reg);
    assign prod  = PROD_W'(d_ext) * PROD_W'(RECIP_2_25);
    assign quo   = prod[RECIP_SHIFT +: QUO_W];

    // d*3 + d*5/10 + d*8/100 = 2d + d + d/2 + floor(2d/25)
    assign d_wide = TICK_W'(d2_reg);
    assign ticks  = (d_wide << 1) + d_wide + (d_wide >> 1) + TICK_W'(q2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            op1_reg  <= in_item.opcode;
            d1_reg   <= in_item.delay[DW-1:0];
            smp1_reg <= in_item.sample;
        end
        if (rdy2 && v1_reg)
        begin
            op2_reg  <= op1_reg;
            d2_reg   <= d1_reg;
            smp2_reg <= smp1_reg;
            q2_reg   <= quo;
        end
        if (rdy3 && v2_reg)
        begin
            op3_reg    <= op2_reg;
            smp3_reg   <= smp2_reg;
            ticks3_reg <= ticks;
        end
    end

    assign out_valid       = v3_reg;
    assign out_item.opcode = op3_reg;
    assign out_item.sample = smp3_reg;
    assign out_item.ticks  = ticks3_reg;

endmodule

/* rtl/core/wrapping_timer_delay_tracker_unit.sv */
// Tracks one microsecond delay against a free-running 24- or 32-bit timer.
// A start word (tuser 0) carries the delay and the current timer count; each
// later sample word (tuser 1) carries a fresh count, and every word returns
// one result word with done in bit 0 and busy in bit 1. The block takes a
// word in every cycle while the result side does not stall, and each word
// passes the input register, the reciprocal multiply
// for the divide by 25 and the tick sum, and the result register then takes
// the updated wrap count, end count and last sample. A stall on the result
// side holds each full stage that has no empty stage after it in the same cycle, while empty stages still
// take new words. Write cfg_wdata (1 = 32-bit timer) only while idle.
`include "wrapping_timer_delay_tracker_unit_defines.svh"

module wrapping_timer_delay_tracker_unit
    import wtdt_pkg::*;
#(
    parameter int DELAY_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // delay_us [31:0], timer_sample [63:32]
    input  logic [0:0]  s_axis_tuser,  // opcode [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // done_res [0], busy_res [1], zeros above
);

    item_t              in_item;
    tick_item_t         tick;
    logic               p_valid;
    logic               p_ready;
    logic               fire;

    logic               mode32_reg;
    logic               running_reg;
    logic               running_next;
    logic [WRAP_W-1:0]  wraps_reg;
    logic [WRAP_W-1:0]  wraps_next;
    logic [TIMER_W-1:0] end_reg;
    logic [TIMER_W-1:0] end_next;
    logic [TIMER_W-1:0] last_reg;
    logic [TIMER_W-1:0] last_next;
    logic               out_valid_reg;
    logic               done_reg;
    logic               done_next;
    logic               busy_reg;

    logic [TIMER_W-1:0] sample;
    logic [TIMER_W-1:0] tick_low;
    logic [TIMER_W:0]   end_sum;
    logic [TIMER_W-1:0] start_end;
    logic [WRAP_W-1:0]  start_wraps;
    logic               start_carry;
    logic               sample_wrapped;
    logic [WRAP_W-1:0]  wraps_dec;

    assign in_item.opcode = s_axis_tuser[0];
    assign in_item.delay  = s_axis_tdata[31:0];
    assign in_item.sample = s_axis_tdata[63:32];

    wtdt_tick_pipe #(
        .DELAY_BITS (DELAY_BITS)
    ) u_tick_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_item  (tick)
    );

    assign p_ready = !out_valid_reg || m_axis_tready;
    assign fire    = p_valid && p_ready;

    // mask the sample and the tick remainder to the timer width
    always_comb
    begin
        if (mode32_reg)
        begin
            sample      = tick.sample;
            tick_low    = tick.ticks[TIMER_W-1:0];
        end
        else
        begin
            sample      = {{(TIMER_W-TIMER_W24){1'b0}}, tick.sample[TIMER_W24-1:0]};
            tick_low    = {{(TIMER_W-TIMER_W24){1'b0}}, tick.ticks[TIMER_W24-1:0]};
        end
    end

    assign end_sum = {1'b0, tick_low} + {1'b0, sample};

    // whole wraps plus the carry out of the remainder; at most 917, no saturation
    always_comb
    begin
        if (mode32_reg)
        begin
            start_carry = end_sum[TIMER_W];
            start_end   = end_sum[TIMER_W-1:0];
            start_wraps = WRAP_W'(tick.ticks[TICK_W-1:TIMER_W]) + WRAP_W'(start_carry);
        end
        else
        begin
            start_carry = end_sum[TIMER_W24];
            start_end   = {{(TIMER_W-TIMER_W24){1'b0}}, end_sum[TIMER_W24-1:0]};
            start_wraps = WRAP_W'(tick.ticks[TICK_W-1:TIMER_W24]) + WRAP_W'(start_carry);
        end
    end

    assign sample_wrapped = sample < last_reg;
    assign wraps_dec      = wraps_reg - WRAP_W'(sample_wrapped);

    always_comb
    begin
        running_next = running_reg;
        wraps_next   = wraps_reg;
        end_next     = end_reg;
        last_next    = last_reg;
        done_next    = 1'b0;
        if (tick.opcode == OP_START)
        begin
            wraps_next   = start_wraps;
            end_next     = start_end;
            last_next    = sample;
            done_next    = (start_wraps == '0) && (start_end <= sample);
            running_next = !done_next;
        end
        else if (running_reg)
        begin
            if (wraps_reg != '0)
            begin
                wraps_next = wraps_dec;
                last_next  = sample;
                done_next  = (wraps_dec == '0) && (end_reg <= sample);
            end
            else if (sample_wrapped)
            begin
                done_next = 1'b1;
            end
            else
            begin
                last_next = sample;
                done_next = end_reg <= sample;
            end
            running_next = !done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode32_reg    <= 1'b0;
            running_reg   <= 1'b0;
            wraps_reg     <= '0;
            end_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode32_reg <= cfg_wdata;
            if (p_ready)
                out_valid_reg <= p_valid;
            if (fire)
            begin
                running_reg <= running_next;
                wraps_reg   <= wraps_next;
                end_reg     <= end_next;
                last_reg    <= last_next;
                done_reg    <= done_next;
                busy_reg    <= running_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, busy_reg, done_reg};

    `WTDT_NEVER(a_done_and_busy, out_valid_reg && done_reg && busy_reg, "done and busy together")
    `WTDT_NEVER(a_idle_wraps, !running_reg && (wraps_reg != '0), "wraps left while idle")
    `WTDT_NEVER(a_wraps_range, wraps_reg > WRAP_W'(1025), "wrap count out of range")
    `WTDT_ASSERT(a_busy_state, out_valid_reg |-> (busy_reg == running_reg), "busy mismatch")

endmodule
